/* sv/gmsp_pkg.sv */
package gmsp_pkg;

  localparam int SIDE    = 9;
  localparam int CELLS   = SIDE * SIDE;
  localparam int IDX_W   = $clog2(SIDE);
  localparam int DEPTH_W = $clog2(CELLS + 1);
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int SUM_W   = DEPTH_W + 1;
  localparam int LEN_W   = 7;

  typedef logic [SIDE-1:0]    row_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [1:0]         move_t;
  typedef logic [LEN_W-1:0]   len_t;

  localparam move_t MOVE_UP    = 2'd0;
  localparam move_t MOVE_DOWN  = 2'd1;
  localparam move_t MOVE_RIGHT = 2'd2;
  localparam move_t MOVE_DONE  = 2'd3;

  typedef struct packed {
    idx_t  row;
    idx_t  col;
    move_t move;
  } frame_t;

  localparam int FRAME_W = $bits(frame_t);

  typedef struct packed {
    logic load;
    logic init;
    logic step;
    logic pop_load;
    logic emit_adv;
  } cmd_t;

  typedef struct packed {
    logic   last_row;
    logic   start_open;
    logic   top_pop;
    logic   depth_one;
    logic   emit_last;
    depth_t depth;
  } stat_t;

endpackage

/* sv/gmsp_ram.sv */
module gmsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/gmsp_ctrl.sv */
module gmsp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           out_ready,
  input  gmsp_pkg::stat_t st,
  output logic           in_ready,
  output logic           out_valid,
  output gmsp_pkg::cmd_t  cmd
);
  import gmsp_pkg::*;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_STEP = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready     = (state == S_LOAD) || ((state == S_EMIT) && !st.last_row);
  assign out_valid    = (state == S_EMIT);
  assign cmd.load     = in_valid && in_ready;
  assign cmd.init     = (state == S_INIT);
  assign cmd.step     = (state == S_STEP);
  assign cmd.pop_load = (state == S_WAIT);
  assign cmd.emit_adv = out_valid && out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_LOAD: begin
        if (cmd.load && st.last_row) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        state_next = st.start_open ? S_STEP : S_EMIT;
      end
      S_STEP: begin
        if (st.top_pop) begin
          state_next = st.depth_one ? S_EMIT : S_WAIT;
        end
      end
      S_WAIT: begin
        state_next = S_STEP;
      end
      S_EMIT: begin
        if (cmd.emit_adv && st.emit_last) begin
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/gmsp_dp.sv */
module gmsp_dp (
  input  logic            clk,
  input  logic            rst,
  input  gmsp_pkg::cmd_t  cmd,
  input  gmsp_pkg::row_t  open_cells,
  output gmsp_pkg::stat_t st,
  output gmsp_pkg::row_t  path_row,
  output gmsp_pkg::len_t  path_length,
  output logic            found,
  output logic            row_last
);
  import gmsp_pkg::*;

  row_t   maze    [SIDE];
  row_t   visited [SIDE];
  row_t   best    [SIDE];
  idx_t   rows_loaded;
  idx_t   emit_idx;
  depth_t depth;
  depth_t best_len;
  logic   seen;
  frame_t top;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  frame_t             ram_wdata;
  logic [FRAME_W-1:0] ram_rdata;

  logic             step_ok;
  idx_t             nr;
  idx_t             nc;
  logic             cand;
  logic [SUM_W-1:0] len;
  logic [SUM_W-1:0] bound;
  logic             prune;
  logic             hit;
  logic             take;
  logic             push;
  logic             pop;

  assign st.last_row   = (rows_loaded == idx_t'(SIDE - 1));
  assign st.start_open = maze[0][0];
  assign st.top_pop    = (top.move == MOVE_DONE);
  assign st.depth_one  = (depth == depth_t'(1));
  assign st.emit_last  = (emit_idx == idx_t'(SIDE - 1));
  assign st.depth      = depth;

  // neighbour for the current move
  always_comb begin
    step_ok = 1'b0;
    nr      = top.row;
    nc      = top.col;
    unique case (top.move)
      MOVE_UP: begin
        step_ok = (top.row != '0);
        nr      = top.row - idx_t'(1);
      end
      MOVE_DOWN: begin
        step_ok = (top.row != idx_t'(SIDE - 1));
        nr      = top.row + idx_t'(1);
      end
      MOVE_RIGHT: begin
        step_ok = (top.col != idx_t'(SIDE - 1));
        nc      = top.col + idx_t'(1);
      end
      MOVE_DONE: begin
        step_ok = 1'b0;
      end
      default: begin
        step_ok = 1'b0;
      end
    endcase
  end

  assign cand  = step_ok && maze[nr][nc] && !visited[nr][nc];
  assign len   = SUM_W'(depth) + SUM_W'(1);
  assign bound = len + SUM_W'(2 * (SIDE - 1)) - SUM_W'(nr) - SUM_W'(nc);
  assign prune = seen && (bound >= SUM_W'(best_len));
  assign hit   = (nr == idx_t'(SIDE - 1)) && (nc == idx_t'(SIDE - 1));
  assign take  = cmd.step && !st.top_pop && cand && !prune;
  assign push  = take && !hit && (depth < depth_t'(CELLS));
  assign pop   = cmd.step && st.top_pop;

  assign ram_we         = push;
  assign ram_waddr      = ADDR_W'(depth - depth_t'(1));
  assign ram_wdata.row  = top.row;
  assign ram_wdata.col  = top.col;
  assign ram_wdata.move = top.move + move_t'(1);
  assign ram_raddr      = ADDR_W'(depth - depth_t'(2));

  gmsp_ram #(
    .WIDTH(FRAME_W),
    .DEPTH(CELLS)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      maze[rows_loaded] <= open_cells;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      visited[0] <= {{(SIDE-1){1'b0}}, maze[0][0]};
      for (int i = 1; i < SIDE; i++) begin
        visited[i] <= '0;
      end
    end else if (push) begin
      visited[nr][nc] <= 1'b1;
    end else if (pop) begin
      visited[top.row][top.col] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      top <= '0;
    end else if (push) begin
      top.row  <= nr;
      top.col  <= nc;
      top.move <= MOVE_UP;
    end else if (cmd.step && !st.top_pop) begin
      top.move <= top.move + move_t'(1);
    end else if (cmd.pop_load) begin
      top <= frame_t'(ram_rdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_loaded <= '0;
      emit_idx    <= '0;
      depth       <= '0;
      best_len    <= '0;
      seen        <= 1'b0;
      for (int i = 0; i < SIDE; i++) begin
        best[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        rows_loaded <= st.last_row ? '0 : rows_loaded + idx_t'(1);
      end
      if (cmd.emit_adv) begin
        emit_idx <= st.emit_last ? '0 : emit_idx + idx_t'(1);
      end
      if (cmd.init) begin
        depth    <= maze[0][0] ? depth_t'(1) : '0;
        best_len <= '0;
        seen     <= 1'b0;
        for (int i = 0; i < SIDE; i++) begin
          best[i] <= '0;
        end
      end else begin
        if (push) begin
          depth <= depth + depth_t'(1);
        end else if (pop) begin
          depth <= depth - depth_t'(1);
        end
        if (take && hit) begin
          for (int i = 0; i < SIDE - 1; i++) begin
            best[i] <= visited[i];
          end
          best[SIDE-1] <= visited[SIDE-1] | {1'b1, {(SIDE-1){1'b0}}};
          best_len     <= depth_t'(len);
          seen         <= 1'b1;
        end
      end
    end
  end

  assign path_row    = best[emit_idx];
  assign path_length = LEN_W'(best_len);
  assign found       = seen;
  assign row_last    = st.emit_last;

endmodule

/* sv/grid_maze_shortest_path_search.sv */
// Grid maze shortest path search.
// Input channel (in_valid/in_ready/open_cells): one maze row per request,
// row 0 first, bit j set when column j is open. A row is accepted in any
// cycle in which in_valid and in_ready are both high.
// The request carrying the last row starts a depth-first backtracking
// search from the top-left to the bottom-right cell. The search has a
// setup state, then tries one move per step state; each backtrack but the
// final one passes through a wait state that reloads the top frame (the
// stack below the top frame lives in a RAM with a registered read port),
// so its length depends on the maze: shortest for a closed start, longest
// for a large open region with no route to the target.
// Output channel (out_valid/out_ready): SIDE results, one per path row,
// each carrying path_row, path_length, found and row_last (set on the
// final row); one per cycle while out_ready is high. A stalled receiver
// simply holds the block in the output phase; rows of the next maze other
// than its last one are still accepted during that phase.
// Reset (rst, synchronous) empties the row count and the search state and
// returns the block to waiting for row 0.
module grid_maze_shortest_path_search (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gmsp_pkg::row_t        open_cells,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gmsp_pkg::row_t        path_row,
  output gmsp_pkg::len_t        path_length,
  output logic                  found,
  output logic                  row_last
);
  import gmsp_pkg::*;

  cmd_t  cmd;
  stat_t st;

  gmsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .out_ready(out_ready),
    .st       (st),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .cmd      (cmd)
  );

  gmsp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .open_cells (open_cells),
    .st         (st),
    .path_row   (path_row),
    .path_length(path_length),
    .found      (found),
    .row_last   (row_last)
  );

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    st.depth <= depth_t'(CELLS))
    else $error("search stack depth beyond grid size");

  a_end_of_results: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && row_last) |=> !out_valid)
    else $error("results continue after final row");

  a_no_path_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (path_length == '0 && path_row == '0))
    else $error("path data present without a path");

  a_no_last_row_in_emit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(in_ready && st.last_row))
    else $error("last maze row accepted while results pending");

endmodule

/* test/tb_grid_maze_shortest_path_search.sv */
module tb_grid_maze_shortest_path_search;
  import gmsp_pkg::*;

  typedef struct {
    row_t row;
    len_t len;
    logic hit;
    logic last;
  } path_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  row_t open_cells = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  row_t path_row;
  len_t path_length;
  logic found;
  logic row_last;

  row_t       row_queue[$];
  path_beat_t expected_rows[$];
  int         fail_count = 0;
  int         in_gap = 0;
  int         out_gap = 0;

  // predictor state
  row_t maze_rows[SIDE];
  int   rows_in = 0;
  row_t best_rows[SIDE];
  int   best_len;
  bit   have_path;

  grid_maze_shortest_path_search uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .open_cells  (open_cells),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .path_row    (path_row),
    .path_length (path_length),
    .found       (found),
    .row_last    (row_last)
  );

  always #5 clk = ~clk;

  // Depth-first search over simple paths, moves up, down, right;
  // branches that cannot beat the kept length are cut.
  function automatic void solve_maze();
    row_t  trail[SIDE];
    int    fr_row[CELLS];
    int    fr_col[CELLS];
    move_t fr_move[CELLS];
    int    depth, r, c, span, i;
    move_t m;
    bit    blocked;
    for (i = 0; i < SIDE; i++) begin
      trail[i] = '0;
      best_rows[i] = '0;
    end
    best_len = 0;
    have_path = 1'b0;
    depth = 0;
    if (maze_rows[0][0]) begin
      trail[0][0] = 1'b1;
      fr_row[0] = 0;
      fr_col[0] = 0;
      fr_move[0] = MOVE_UP;
      depth = 1;
    end
    while (depth > 0) begin
      r = fr_row[depth-1];
      c = fr_col[depth-1];
      m = fr_move[depth-1];
      if (m == MOVE_DONE) begin
        trail[r][c] = 1'b0;
        depth--;
      end else begin
        fr_move[depth-1] = m + move_t'(1);
        blocked = 1'b0;
        case (m)
          MOVE_UP:   if (r == 0) blocked = 1'b1; else r--;
          MOVE_DOWN: if (r == SIDE-1) blocked = 1'b1; else r++;
          default:   if (c == SIDE-1) blocked = 1'b1; else c++;
        endcase
        if (!blocked && maze_rows[r][c] && !trail[r][c]) begin
          span = depth + 1 + (SIDE-1-r) + (SIDE-1-c);
          if (!have_path || span < best_len) begin
            if (r == SIDE-1 && c == SIDE-1) begin
              best_rows = trail;
              best_rows[r][c] = 1'b1;
              best_len = depth + 1;
              have_path = 1'b1;
            end else begin
              trail[r][c] = 1'b1;
              fr_row[depth] = r;
              fr_col[depth] = c;
              fr_move[depth] = MOVE_UP;
              depth++;
            end
          end
        end
      end
    end
  endfunction

  function automatic void take_row(row_t bits);
    path_beat_t beat;
    int i;
    maze_rows[rows_in] = bits;
    rows_in++;
    if (rows_in == SIDE) begin
      rows_in = 0;
      solve_maze();
      for (i = 0; i < SIDE; i++) begin
        beat.row  = best_rows[i];
        beat.len  = len_t'(best_len);
        beat.hit  = have_path;
        beat.last = (i == SIDE-1);
        expected_rows = {expected_rows, beat};
      end
    end
  endfunction

  function automatic void queue_maze(row_t rows[SIDE]);
    int i;
    for (i = 0; i < SIDE; i++) row_queue = {row_queue, rows[i]};
  endfunction

  // tidy mazes have both corners open and a carved route; others are sparse noise
  function automatic void queue_random_maze(bit tidy);
    row_t rows[SIDE];
    int   pct, r, c;
    pct = tidy ? $urandom_range(45, 95) : $urandom_range(0, 55);
    for (r = 0; r < SIDE; r++) begin
      rows[r] = '0;
      for (c = 0; c < SIDE; c++)
        if ($urandom_range(0, 99) < pct) rows[r][c] = 1'b1;
    end
    if (tidy) begin
      r = 0;
      c = 0;
      rows[0][0] = 1'b1;
      while (!(r == SIDE-1 && c == SIDE-1)) begin
        if (c == SIDE-1 || (r < SIDE-1 && $urandom_range(0, 1) == 1)) r++;
        else c++;
        rows[r][c] = 1'b1;
      end
    end
    queue_maze(rows);
  endfunction

  always @(posedge clk) begin : drive_rows
    logic nv;
    row_t nd;
    if (rst) begin
      in_valid <= 1'b0;
      open_cells <= '0;
      in_gap <= 0;
    end else begin
      nv = in_valid;
      nd = open_cells;
      if (in_valid && in_ready) begin
        take_row(open_cells);
        nv = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (row_queue.size() > 0) begin
          if (row_queue.size() > 27 && $urandom_range(0, 7) == 0) begin
            in_gap <= $urandom_range(0, 10);
          end else begin
            nv = 1'b1;
            nd = row_queue.pop_front();
          end
        end
      end
      in_valid <= nv;
      open_cells <= nd;
    end
  end

  always @(posedge clk) begin : check_rows
    path_beat_t want;
    if (rst) begin
      out_ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rows.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: row=%h len=%0d found=%b last=%b",
                     path_row, path_length, found, row_last);
          fail_count++;
        end else begin
          want = expected_rows.pop_front();
          if (path_row !== want.row || path_length !== want.len ||
              found !== want.hit || row_last !== want.last) begin
            if (fail_count < 10)
              $display("mismatch: exp row=%h len=%0d found=%b last=%b,",
                       want.row, want.len, want.hit, want.last,
                       " got row=%h len=%0d found=%b last=%b",
                       path_row, path_length, found, row_last);
            fail_count++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (row_queue.size() > 27 && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    row_t rows[SIDE];
    int i;
    // open grid: many tied shortest routes
    for (i = 0; i < SIDE; i++) rows[i] = '1;
    queue_maze(rows);
    // closed start
    rows[0][0] = 1'b0;
    queue_maze(rows);
    // closed target, an empty row as well
    rows[0][0] = 1'b1;
    rows[SIDE-1][SIDE-1] = 1'b0;
    rows[4] = '0;
    queue_maze(rows);
    for (i = 0; i < 13; i++) queue_random_maze(i % 4 != 3);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (row_queue.size() != 0 || in_valid) @(posedge clk);
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #1000000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
